// File: src/rtpsrb_pkg.sv
// Shared types and constants of the RTP sequence reorder buffer.
package rtpsrb_pkg;

    localparam int SLOTS_DEF = 32;

    localparam logic [1:0] KIND_PKT   = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    localparam logic [1:0] ACT_FWD  = 2'd0;
    localparam logic [1:0] ACT_HELD = 2'd1;
    localparam logic [1:0] ACT_DROP = 2'd2;
    localparam logic [1:0] ACT_REL  = 2'd3;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS_CHK,
        ST_POP_RD,
        ST_POP,
        ST_CASC_RD,
        ST_CASC_CHK,
        ST_END,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       ready;
        logic       emit;
        logic [1:0] emit_act;
        logic       fwd;
        logic       tick;
        logic       flush;
        logic       srch_read;
        logic       idx_inc;
        logic       set_pos;
        logic       shift_read;
        logic       shift_write;
        logic       insert;
        logic       head_read;
        logic       pop;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] kind;
        logic       fwd_ok;
        logic       late;
        logic       fire_any;
        logic       flush_any;
        logic       idx_eq_cnt;
        logic       rd_lt;
        logic       rd_eq;
        logic       k_eq_pos;
        logic       cnt_zero;
        logic       overflow;
        logic       newpos_valid;
        logic       can_emit;
        logic       pend_valid;
        logic       head_match;
    } status_t;

endpackage

// File: src/rtpsrb_ctrl.sv
// Controller state machine of the RTP sequence reorder buffer.
module rtpsrb_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  rtpsrb_pkg::status_t st,
    output rtpsrb_pkg::cmd_t  cmd
);
    import rtpsrb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (st.in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (st.kind)
                    KIND_PKT:
                    begin
                        if (st.fwd_ok)
                        begin
                            if (st.can_emit)
                            begin
                                state_next = ST_CASC_RD;
                            end
                        end
                        else if (st.late)
                        begin
                            if (st.can_emit)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        else
                        begin
                            state_next = ST_SRCH_RD;
                        end
                    end
                    KIND_TICK:  state_next = st.fire_any ? ST_POP_RD : ST_FINISH;
                    KIND_FLUSH: state_next = st.flush_any ? ST_POP_RD : ST_FINISH;
                    default:    state_next = ST_FINISH;
                endcase
            end
            ST_SRCH_RD:  state_next = st.idx_eq_cnt ? ST_SH_RD : ST_SRCH_CHK;
            ST_SRCH_CHK:
            begin
                if (st.rd_lt)
                begin
                    state_next = ST_SRCH_RD;
                end
                else if (st.rd_eq)
                begin
                    if (st.can_emit)
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    state_next = ST_SH_RD;
                end
            end
            ST_SH_RD:    state_next = st.k_eq_pos ? ST_INS_CHK : ST_SH_WR;
            ST_SH_WR:    state_next = ST_SH_RD;
            ST_INS_CHK:  state_next = st.overflow ? ST_POP_RD : ST_END;
            ST_POP_RD:   state_next = ST_POP;
            ST_POP:
            begin
                if (st.can_emit)
                begin
                    state_next = ST_CASC_RD;
                end
            end
            ST_CASC_RD:  state_next = st.cnt_zero ? ST_END : ST_CASC_CHK;
            ST_CASC_CHK: state_next = st.head_match ? ST_POP : ST_END;
            ST_END:
            begin
                if (!st.newpos_valid || st.can_emit)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!st.pend_valid || st.can_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:     cmd.ready = 1'b1;
            ST_DECODE:
            begin
                unique case (st.kind)
                    KIND_PKT:
                    begin
                        if (st.fwd_ok)
                        begin
                            cmd.emit     = st.can_emit;
                            cmd.fwd      = st.can_emit;
                            cmd.emit_act = ACT_FWD;
                        end
                        else if (st.late)
                        begin
                            cmd.emit     = st.can_emit;
                            cmd.emit_act = ACT_DROP;
                        end
                    end
                    KIND_TICK:  cmd.tick  = 1'b1;
                    KIND_FLUSH: cmd.flush = 1'b1;
                    default:    cmd.ready = 1'b0;
                endcase
            end
            ST_SRCH_RD:
            begin
                cmd.set_pos   = st.idx_eq_cnt;
                cmd.srch_read = !st.idx_eq_cnt;
            end
            ST_SRCH_CHK:
            begin
                if (st.rd_lt)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else if (st.rd_eq)
                begin
                    cmd.emit     = st.can_emit;
                    cmd.emit_act = ACT_DROP;
                end
                else
                begin
                    cmd.set_pos = 1'b1;
                end
            end
            ST_SH_RD:
            begin
                cmd.insert     = st.k_eq_pos;
                cmd.shift_read = !st.k_eq_pos;
            end
            ST_SH_WR:    cmd.shift_write = 1'b1;
            ST_POP_RD:   cmd.head_read = 1'b1;
            ST_POP:
            begin
                cmd.pop  = st.can_emit;
                cmd.emit = st.can_emit;
            end
            ST_CASC_RD:  cmd.head_read = !st.cnt_zero;
            ST_END:
            begin
                cmd.emit     = st.newpos_valid && st.can_emit;
                cmd.emit_act = ACT_HELD;
            end
            ST_FINISH:   cmd.finish = st.pend_valid && st.can_emit;
            default:     cmd.ready = 1'b0;
        endcase
    end

endmodule

// File: src/rtpsrb_dp.sv
// Datapath of the RTP sequence reorder buffer: direction state, slot memory, output stage.
module rtpsrb_dp
#(
    parameter int SLOTS = rtpsrb_pkg::SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              s_axis_tvalid,
    input  logic [55:0]       s_axis_tdata,
    input  logic [1:0]        s_axis_tuser,
    output logic [39:0]       m_axis_tdata,
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  rtpsrb_pkg::cmd_t  cmd,
    output rtpsrb_pkg::status_t st
);
    import rtpsrb_pkg::*;

    localparam int PW    = $clog2(SLOTS + 1);
    localparam int CW    = $clog2(SLOTS + 2);
    localparam int DEPTH = 2 * (2 ** PW);

    logic [15:0]   timeout_reg;
    logic [15:0]   limit_reg;
    logic [15:0]   exp_reg   [2];
    logic          known_reg [2];
    logic [CW-1:0] cnt_reg   [2];
    logic [25:0]   held_reg  [2];
    logic [15:0]   tleft_reg [2];
    logic          trun_reg  [2];
    logic [PW-1:0] head_reg  [2];

    logic [1:0]    kind_reg;
    logic          d_reg;
    logic [15:0]   seq_in_reg;
    logic [15:0]   len_in_reg;
    logic [15:0]   tag_in_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] newpos_reg;
    logic          newpos_valid_reg;

    logic [15:0]   mem_seq [DEPTH];
    logic [15:0]   mem_len [DEPTH];
    logic [15:0]   mem_tag [DEPTH];
    logic [15:0]   rd_seq_reg;
    logic [15:0]   rd_len_reg;
    logic [15:0]   rd_tag_reg;

    logic          pend_valid_reg;
    logic [1:0]    pend_act_reg;
    logic          pend_dir_reg;
    logic [15:0]   pend_seq_reg;
    logic [15:0]   pend_tag_reg;
    logic          out_valid_reg;
    logic [1:0]    out_act_reg;
    logic          out_dir_reg;
    logic [15:0]   out_seq_reg;
    logic [15:0]   out_tag_reg;
    logic          out_last_reg;

    logic          accept;
    logic [15:0]   exp_cur;
    logic [CW-1:0] cnt_cur;
    logic [PW-1:0] head_cur;
    logic [15:0]   left_nx [2];
    logic          fire0;
    logic          fire1;
    logic          stop0;
    logic          stop1;
    logic          rd_en;
    logic [PW-1:0] rd_off;
    logic          wr_en;
    logic [PW-1:0] wr_off;
    logic [15:0]   wr_seq;
    logic [15:0]   wr_len;
    logic [15:0]   wr_tag;
    logic [1:0]    new_act;
    logic          new_dir;
    logic [15:0]   new_seq;
    logic [15:0]   new_tag;
    logic          push;
    logic [CW-1:0] cnt_dec;

    assign accept   = cmd.ready && s_axis_tvalid;
    assign exp_cur  = exp_reg[d_reg];
    assign cnt_cur  = cnt_reg[d_reg];
    assign head_cur = head_reg[d_reg];
    assign cnt_dec  = cnt_cur - CW'(1);

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            left_nx[i] = (trun_reg[i] && tleft_reg[i] != 16'd0) ? tleft_reg[i] - 16'd1
                                                                : tleft_reg[i];
        end
    end

    assign fire0 = trun_reg[0] && left_nx[0] == 16'd0 && cnt_reg[0] != '0;
    assign fire1 = trun_reg[1] && left_nx[1] == 16'd0 && cnt_reg[1] != '0;
    assign stop0 = trun_reg[0] && left_nx[0] == 16'd0 && cnt_reg[0] == '0;
    assign stop1 = trun_reg[1] && left_nx[1] == 16'd0 && cnt_reg[1] == '0 && !fire0;

    always_comb
    begin
        st              = '0;
        st.in_valid     = s_axis_tvalid;
        st.kind         = kind_reg;
        st.late         = known_reg[d_reg]
                          && ({1'b0, seq_in_reg} + 17'd1) < {1'b0, exp_cur};
        st.fwd_ok       = !known_reg[d_reg] || (!st.late && seq_in_reg <= exp_cur);
        st.fire_any     = fire0 || fire1;
        st.flush_any    = cnt_reg[0] != '0 || cnt_reg[1] != '0;
        st.idx_eq_cnt   = idx_reg == cnt_cur;
        st.rd_lt        = rd_seq_reg < seq_in_reg;
        st.rd_eq        = rd_seq_reg == seq_in_reg;
        st.k_eq_pos     = k_reg == pos_reg;
        st.cnt_zero     = cnt_cur == '0;
        st.overflow     = cnt_cur > CW'(SLOTS) || held_reg[d_reg] > {limit_reg, 10'd0};
        st.newpos_valid = newpos_valid_reg;
        st.can_emit     = !pend_valid_reg || !out_valid_reg || m_axis_tready;
        st.pend_valid   = pend_valid_reg;
        st.head_match   = rd_seq_reg == exp_cur;
    end

    // Slot memory: each direction owns a circular region, head_reg marks its lowest seq.
    always_comb
    begin
        rd_en  = cmd.srch_read || cmd.shift_read || cmd.head_read;
        rd_off = head_cur;
        if (cmd.srch_read)
        begin
            rd_off = head_cur + idx_reg[PW-1:0];
        end
        else if (cmd.shift_read)
        begin
            rd_off = head_cur + k_reg[PW-1:0] - PW'(1);
        end
        wr_en  = cmd.shift_write || cmd.insert;
        wr_off = cmd.insert ? head_cur + pos_reg[PW-1:0] : head_cur + k_reg[PW-1:0];
        wr_seq = cmd.insert ? seq_in_reg : rd_seq_reg;
        wr_len = cmd.insert ? len_in_reg : rd_len_reg;
        wr_tag = cmd.insert ? tag_in_reg : rd_tag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_seq[{d_reg, wr_off}] <= wr_seq;
            mem_len[{d_reg, wr_off}] <= wr_len;
            mem_tag[{d_reg, wr_off}] <= wr_tag;
        end
        if (rd_en)
        begin
            rd_seq_reg <= mem_seq[{d_reg, rd_off}];
            rd_len_reg <= mem_len[{d_reg, rd_off}];
            rd_tag_reg <= mem_tag[{d_reg, rd_off}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= s_axis_tuser;
            seq_in_reg <= s_axis_tdata[16:1];
            len_in_reg <= s_axis_tdata[32:17];
            tag_in_reg <= s_axis_tdata[48:33];
        end
        if (accept || cmd.idx_inc)
        begin
            idx_reg <= accept ? '0 : idx_reg + CW'(1);
        end
        if (cmd.set_pos)
        begin
            pos_reg <= idx_reg;
            k_reg   <= cnt_cur;
        end
        else if (cmd.shift_write)
        begin
            k_reg <= k_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg            <= 1'b0;
            newpos_valid_reg <= 1'b0;
            newpos_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                d_reg            <= s_axis_tdata[0];
                newpos_valid_reg <= 1'b0;
            end
            else if (cmd.tick)
            begin
                d_reg <= !fire0;
            end
            else if (cmd.flush)
            begin
                d_reg <= cnt_reg[0] == '0;
            end
            if (cmd.insert)
            begin
                newpos_reg       <= pos_reg;
                newpos_valid_reg <= 1'b1;
            end
            else if (cmd.pop && newpos_valid_reg)
            begin
                newpos_reg       <= newpos_reg - CW'(1);
                newpos_valid_reg <= newpos_reg != '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd3;
            limit_reg   <= 16'd80;
            for (int i = 0; i < 2; i++)
            begin
                exp_reg[i]   <= '0;
                known_reg[i] <= 1'b0;
                cnt_reg[i]   <= '0;
                held_reg[i]  <= '0;
                tleft_reg[i] <= '0;
                trun_reg[i]  <= 1'b0;
                head_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    CFG_LIMIT:   limit_reg   <= cfg_data;
                    default:     timeout_reg <= timeout_reg;
                endcase
            end
            if (cmd.fwd)
            begin
                known_reg[d_reg] <= 1'b1;
                exp_reg[d_reg]   <= seq_in_reg + 16'd1;
            end
            if (cmd.tick)
            begin
                tleft_reg[0] <= left_nx[0];
                tleft_reg[1] <= left_nx[1];
                if (stop0)
                begin
                    trun_reg[0] <= 1'b0;
                end
                if (stop1)
                begin
                    trun_reg[1] <= 1'b0;
                end
            end
            if (cmd.insert)
            begin
                if (cnt_cur == '0)
                begin
                    trun_reg[d_reg]  <= 1'b1;
                    tleft_reg[d_reg] <= timeout_reg;
                end
                cnt_reg[d_reg]  <= cnt_cur + CW'(1);
                held_reg[d_reg] <= held_reg[d_reg] + {10'd0, len_in_reg};
            end
            if (cmd.pop)
            begin
                head_reg[d_reg] <= head_cur + PW'(1);
                cnt_reg[d_reg]  <= cnt_dec;
                held_reg[d_reg] <= held_reg[d_reg] - {10'd0, rd_len_reg};
                exp_reg[d_reg]  <= rd_seq_reg + 16'd1;
                trun_reg[d_reg]  <= cnt_dec != '0;
                tleft_reg[d_reg] <= (cnt_dec != '0) ? timeout_reg : 16'd0;
            end
        end
    end

    // Results wait in a pending register so the last flag is known when they leave.
    always_comb
    begin
        new_dir = d_reg;
        if (cmd.pop)
        begin
            new_act = (newpos_valid_reg && newpos_reg == '0) ? ACT_FWD : ACT_REL;
            new_seq = rd_seq_reg;
            new_tag = rd_tag_reg;
        end
        else
        begin
            new_act = cmd.emit_act;
            new_seq = seq_in_reg;
            new_tag = tag_in_reg;
        end
    end

    assign push = pend_valid_reg && (cmd.emit || cmd.finish);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_act_reg <= new_act;
            pend_dir_reg <= new_dir;
            pend_seq_reg <= new_seq;
            pend_tag_reg <= new_tag;
        end
        if (push)
        begin
            out_act_reg  <= pend_act_reg;
            out_dir_reg  <= pend_dir_reg;
            out_seq_reg  <= pend_seq_reg;
            out_tag_reg  <= pend_tag_reg;
            out_last_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_act_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_tag_reg, out_seq_reg, out_dir_reg};

endmodule

// File: src/rtp_sequence_reorder_buffer.sv
// Top level of the RTP sequence reorder buffer.
// Reorders the packets of one two-direction connection by 16-bit sequence number; each
// direction keeps up to SLOTS held packets sorted in a single-port slot memory. The block
// takes one word at a time. Its work on a word grows with each slot walked in the sorted
// search, each entry shifted on insert and each packet released, all through the one
// slot memory port; result words that wait on tready add to it. An insert into a full
// store of 32 slots can overflow and then release all 33 entries.
// Each word yields zero or more result words, the last one marked by tlast.
module rtp_sequence_reorder_buffer
#(
    parameter int SLOTS = rtpsrb_pkg::SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // dir, seq, frame_len, frame_tag, zero fill
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_dir, out_seq, out_tag, zero fill
    output logic [1:0]  m_axis_tuser,   // action
    output logic        m_axis_tlast
);
    import rtpsrb_pkg::*;

    cmd_t    cmd;
    status_t st;

    rtpsrb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    rtpsrb_dp #(.SLOTS(SLOTS)) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .st            (st)
    );

    assign s_axis_tready = cmd.ready;

endmodule
